>>> hdl/cdrrk4_pkg.sv
// Shared types, constants and fixed-point helpers for the drive-response RK4 core.
package cdrrk4_pkg;

  localparam int NUM_EQUATIONS = 3;
  localparam int FRAC_BITS     = 24;
  localparam int ADDR_W        = 4;
  localparam int ACC_W         = 35;
  localparam int OPA_W         = 36;
  localparam int PROD_W        = 68;
  localparam int WIDE_W        = 72;
  localparam int DIV_W         = 40;
  localparam int DIV_STEPS     = 5;

  localparam logic [31:0] GAMMA_RST = 32'd14596177;
  localparam logic [31:0] ALPHA_RST = 32'd18454938;
  localparam logic [24:0] STEP_RST  = 25'd167772;
  localparam logic [15:0] TOL_RST   = 16'd8;

  // Keeps the dividend of the divide-by-six positive: 6 * 2^35.
  localparam logic [DIV_W-1:0] DIV_OFS = 40'd206158430208;

  typedef enum logic [1:0] {
    REG_GAMMA = 2'd0,
    REG_ALPHA = 2'd1,
    REG_STEP  = 2'd2,
    REG_TOL   = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_XX, OP_YU, OP_GX, OP_XC, OP_GY, OP_XY, OP_ZE, OP_H0, OP_H1, OP_H2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_WB, ST_DIV, ST_FIN, ST_DONE
  } state_t;

  typedef struct packed {
    logic               action;
    logic signed [31:0] load_resp_x;
    logic signed [31:0] load_resp_y;
    logic signed [31:0] load_resp_z;
    logic signed [31:0] load_drive_x;
    logic signed [31:0] load_drive_y;
    logic signed [31:0] load_drive_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] resp_x;
    logic signed [31:0] resp_y;
    logic signed [31:0] resp_z;
    logic signed [31:0] drive_x;
    logic signed [31:0] drive_y;
    logic signed [31:0] drive_z;
    logic               in_sync;
    logic               sync_seen;
    logic        [31:0] sync_step;
    logic        [31:0] step_count;
  } out_item_t;

  typedef struct packed {
    logic signed [OPA_W-1:0] a;
    logic signed [31:0]      b;
  } mul_op_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_stat_t;

  function automatic logic signed [WIDE_W-1:0] ext32(input logic signed [31:0] a);
    return {{(WIDE_W-32){a[31]}}, a};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    if (v > $signed(72'sd2147483647)) return 32'sh7fffffff;
    else if (v < -$signed(72'sd2147483648)) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // Round a product to Q8.24 (or half of it when half_sc is set), then saturate.
  function automatic logic signed [31:0] qrnd(input logic signed [PROD_W-1:0] p,
                                              input logic half_sc);
    logic signed [WIDE_W-1:0] w;
    w = {{(WIDE_W-PROD_W){p[PROD_W-1]}}, p};
    if (half_sc) w = (w + (72'sd1 <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
    else         w = (w + (72'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return sat32(w);
  endfunction

endpackage

>>> hdl/cdrrk4_mul.sv
// Shared signed multiplier with a registered product.
module cdrrk4_mul
  import cdrrk4_pkg::*;
(
  input  logic                     clk,
  input  mul_op_t                  op,
  output logic signed [PROD_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= PROD_W'($signed(op.a)) * PROD_W'($signed(op.b));
  end

endmodule

>>> hdl/cdrrk4_div6.sv
// Divide-by-six unit, eight quotient bits per cycle, MSB first.
module cdrrk4_div6
  import cdrrk4_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  output div_stat_t        stat
);

  logic [DIV_W-1:0] num_r;
  logic [DIV_W-1:0] quo_r;
  logic [2:0]       rem_r;
  logic [2:0]       cnt_r;
  logic             done_r;
  logic [3:0]       rem_w;
  logic [7:0]       qb;

  always_comb begin
    rem_w = {1'b0, rem_r};
    qb    = '0;
    for (int i = 7; i >= 0; i--) begin
      rem_w = {rem_w[2:0], num_r[DIV_W-8+i]};
      if (rem_w >= 4'd6) begin
        rem_w = rem_w - 4'd6;
        qb[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= 3'(DIV_STEPS);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == 3'd1);
      if (cnt_r != '0) cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      num_r <= {num_r[DIV_W-9:0], 8'd0};
      rem_r <= rem_w[2:0];
      quo_r <= {quo_r[DIV_W-9:0], qb};
    end
  end

  assign stat.done = done_r;
  assign stat.quo  = quo_r;

endmodule

>>> hdl/chaotic_drive_response_rk4_core.sv
// Top level: drive-response Rabinovich-Fabrikant RK4 core with APB register port.
//
// Holds a drive and a response state (x,y,z, signed Q8.24). A load item (action 0)
// sets both states and clears step count and sync latch; its result goes through the
// done state into the output register. A step item (action 1) copies drive y into the
// response, advances each system by one RK4 step of size dt, then compares all three
// differences with the tolerance and latches the first step at which they agree.
// All multiplications run through one 36x32 multiplier: each of the 40 products of one
// system's RK4 step passes through an issue and a writeback state, and each of the
// three final updates also waits on the divide-by-six unit. One item is in work at a
// time; a finished result sits in the output register, and the next item may be
// accepted while it waits. Registers are to be written only while idle; the block
// itself does not enforce this.
module chaotic_drive_response_rk4_core
  import cdrrk4_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // config registers
  logic signed [31:0] gamma_r, alpha_r;
  logic [24:0]        step_r;
  logic [15:0]        tol_r;

  // architectural state
  logic signed [31:0] resp_r  [NUM_EQUATIONS];
  logic signed [31:0] drive_r [NUM_EQUATIONS];
  logic [31:0]        steps_r, first_r;
  logic               latched_r, agree_r;

  // working registers
  logic signed [31:0]      t_r   [NUM_EQUATIONS];
  logic signed [31:0]      d_r   [NUM_EQUATIONS];
  logic signed [ACC_W-1:0] acc_r [NUM_EQUATIONS];
  logic signed [31:0]      xx_r, tmp_r;

  state_t     state_r, state_nxt;
  op_t        op_r;
  logic [1:0] stage_r;
  logic       sys_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  mul_op_t                  mop;
  logic signed [PROD_W-1:0] p_r;
  logic                     div_start;
  logic [DIV_W-1:0]         div_num;
  div_stat_t                div_st;

  logic signed [31:0]       h32, u_w, c_w, r24, r25, d2_w, v_j;
  logic signed [PROD_W-1:0] q1_w;
  logic [1:0]               j_w;
  logic                     in_acc, wr_en, agree_w, out_load;
  logic [31:0]              steps_inc;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    unique case (paddr[3:2])
      REG_GAMMA: prdata = gamma_r;
      REG_ALPHA: prdata = alpha_r;
      REG_STEP:  prdata = {7'd0, step_r};
      REG_TOL:   prdata = {16'd0, tol_r};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GAMMA_RST;
      alpha_r <= ALPHA_RST;
      step_r  <= STEP_RST;
      tol_r   <= TOL_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_GAMMA: gamma_r <= pwdata;
        REG_ALPHA: alpha_r <= pwdata;
        REG_STEP:  step_r  <= pwdata[24:0];
        REG_TOL:   tol_r   <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  // --- shared datapath -----------------------------------------------------
  assign h32 = {7'd0, step_r};

  always_comb begin
    unique case (op_r)
      OP_H1:   j_w = 2'd1;
      OP_H2:   j_w = 2'd2;
      default: j_w = 2'd0;
    endcase
  end

  assign v_j = sys_r ? drive_r[j_w] : resp_r[j_w];

  // z - 1 + x^2 and 3z + 1 - x^2, both from the x^2 held in xx_r
  assign u_w = sat32(ext32(sat32(ext32(t_r[2]) - (72'sd1 <<< FRAC_BITS))) + ext32(xx_r));
  assign c_w = sat32(ext32(sat32(ext32(sat32(ext32(t_r[2]) * 72'sd3))
                                 + (72'sd1 <<< FRAC_BITS))) - ext32(xx_r));

  always_comb begin
    mop = '0;
    unique case (op_r)
      OP_XX: begin mop.a = OPA_W'(t_r[0]); mop.b = t_r[0]; end
      OP_YU: begin mop.a = OPA_W'(t_r[1]); mop.b = u_w;    end
      OP_GX: begin mop.a = OPA_W'(gamma_r); mop.b = t_r[0]; end
      OP_XC: begin mop.a = OPA_W'(t_r[0]); mop.b = c_w;    end
      OP_GY: begin mop.a = OPA_W'(gamma_r); mop.b = t_r[1]; end
      OP_XY: begin mop.a = OPA_W'(t_r[0]); mop.b = t_r[1]; end
      OP_ZE: begin mop.a = OPA_W'(t_r[2]); mop.b = tmp_r;  end
      OP_H0, OP_H1, OP_H2: begin
        if (stage_r == 2'd3) begin
          mop.a = OPA_W'(acc_r[j_w]);
          mop.b = h32;
        end else begin
          mop.a = OPA_W'(h32);
          mop.b = d_r[j_w];
        end
      end
      default: ;
    endcase
  end

  cdrrk4_mul u_mul (
    .clk (clk),
    .op  (mop),
    .p_r (p_r)
  );

  assign r24  = qrnd(p_r, 1'b0);
  assign r25  = qrnd(p_r, 1'b1);
  assign d2_w = sat32(ext32(r24) * -72'sd2);

  // floor((p + 3 * 2^24) / 2^24) then floor(. / 6) with the dividend biased positive
  assign q1_w      = (p_r + (68'sd3 <<< FRAC_BITS)) >>> FRAC_BITS;
  assign div_num   = q1_w[DIV_W-1:0] + DIV_OFS;
  assign div_start = (state_r == ST_WB) && (stage_r == 2'd3) &&
                     (op_r == OP_H0 || op_r == OP_H1 || op_r == OP_H2);

  cdrrk4_div6 u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .stat  (div_st)
  );

  // --- sync check ------------------------------------------------------------
  always_comb begin
    logic signed [WIDE_W-1:0] df;
    agree_w = 1'b1;
    for (int j = 0; j < NUM_EQUATIONS; j++) begin
      df = ext32(drive_r[j]) - ext32(resp_r[j]);
      if (df < 0) df = -df;
      if (df > $signed({56'd0, tol_r})) agree_w = 1'b0;
    end
  end

  assign steps_inc = (steps_r == 32'hffffffff) ? steps_r : steps_r + 32'd1;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // --- sequencer -------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = in_data.action ? ST_ISSUE : ST_DONE;
      ST_ISSUE: state_nxt = ST_WB;
      ST_WB: begin
        if (div_start) state_nxt = ST_DIV;
        else           state_nxt = ST_ISSUE;
      end
      ST_DIV: begin
        if (div_st.done) begin
          if (op_r == OP_H2 && sys_r) state_nxt = ST_FIN;
          else                        state_nxt = ST_ISSUE;
        end
      end
      ST_FIN:  state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // op / stage / system counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r    <= OP_XX;
      stage_r <= '0;
      sys_r   <= 1'b0;
    end else if (in_acc) begin
      op_r    <= OP_XX;
      stage_r <= '0;
      sys_r   <= 1'b0;
    end else if (state_r == ST_WB && !div_start) begin
      if (op_r == OP_H2) begin
        op_r    <= OP_XX;
        stage_r <= stage_r + 2'd1;
      end else begin
        op_r <= op_t'(op_r + 4'd1);
      end
    end else if (state_r == ST_DIV && div_st.done) begin
      if (op_r == OP_H2) begin
        op_r    <= OP_XX;
        stage_r <= '0;
        sys_r   <= 1'b1;
      end else begin
        op_r <= op_t'(op_r + 4'd1);
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      t_r[0] <= resp_r[0];
      t_r[1] <= drive_r[1];
      t_r[2] <= resp_r[2];
    end else if (state_r == ST_DIV && div_st.done && op_r == OP_H2 && !sys_r) begin
      for (int j = 0; j < NUM_EQUATIONS; j++) t_r[j] <= drive_r[j];
    end else if (state_r == ST_WB) begin
      unique case (op_r)
        OP_XX: xx_r  <= r24;
        OP_YU: tmp_r <= r24;
        OP_GX: d_r[0] <= sat32(ext32(tmp_r) + ext32(r24));
        OP_XC: tmp_r <= r24;
        OP_GY: d_r[1] <= sat32(ext32(tmp_r) + ext32(r24));
        OP_XY: tmp_r <= sat32(ext32(alpha_r) + ext32(r24));
        OP_ZE: begin
          d_r[2] <= d2_w;
          // k1 + 2k2 + 2k3 + k4, exact
          for (int j = 0; j < NUM_EQUATIONS; j++) begin
            logic signed [ACC_W-1:0] kv, base;
            kv   = (j == 2) ? ACC_W'(d2_w) : ACC_W'(d_r[j]);
            base = (stage_r == 2'd0) ? '0 : acc_r[j];
            if (stage_r == 2'd1 || stage_r == 2'd2) acc_r[j] <= base + (kv <<< 1);
            else                                    acc_r[j] <= base + kv;
          end
        end
        OP_H0, OP_H1, OP_H2: begin
          if (stage_r != 2'd3)
            t_r[j_w] <= sat32(ext32(v_j) + ext32((stage_r == 2'd2) ? r24 : r25));
        end
        default: ;
      endcase
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NUM_EQUATIONS; j++) begin
        resp_r[j]  <= '0;
        drive_r[j] <= '0;
      end
      steps_r   <= '0;
      first_r   <= '0;
      latched_r <= 1'b0;
      agree_r   <= 1'b0;
    end else if (in_acc) begin
      if (!in_data.action) begin
        resp_r[0]  <= in_data.load_resp_x;
        resp_r[1]  <= in_data.load_resp_y;
        resp_r[2]  <= in_data.load_resp_z;
        drive_r[0] <= in_data.load_drive_x;
        drive_r[1] <= in_data.load_drive_y;
        drive_r[2] <= in_data.load_drive_z;
        steps_r    <= '0;
        first_r    <= '0;
        latched_r  <= 1'b0;
        agree_r    <= 1'b0;
      end else begin
        resp_r[1] <= drive_r[1];
      end
    end else if (state_r == ST_DIV && div_st.done) begin
      if (sys_r)
        drive_r[j_w] <= sat32(ext32(v_j) + {32'd0, div_st.quo} - (72'sd1 <<< 35));
      else
        resp_r[j_w]  <= sat32(ext32(v_j) + {32'd0, div_st.quo} - (72'sd1 <<< 35));
    end else if (state_r == ST_FIN) begin
      steps_r <= steps_inc;
      agree_r <= agree_w;
      if (agree_w && !latched_r) begin
        latched_r <= 1'b1;
        first_r   <= steps_inc;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n)          out_valid_r <= 1'b0;
    else if (out_load)   out_valid_r <= 1'b1;
    else if (out_ready)  out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.resp_x     <= resp_r[0];
      out_data_r.resp_y     <= resp_r[1];
      out_data_r.resp_z     <= resp_r[2];
      out_data_r.drive_x    <= drive_r[0];
      out_data_r.drive_y    <= drive_r[1];
      out_data_r.drive_z    <= drive_r[2];
      out_data_r.in_sync    <= agree_r;
      out_data_r.sync_seen  <= latched_r;
      out_data_r.sync_step  <= first_r;
      out_data_r.step_count <= steps_r;
    end
  end

endmodule

>>> hdl/cdrrk4_checker.sv
// Port-level checker for the drive-response RK4 core, bound to the top level.
module cdrrk4_checker
  import cdrrk4_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input out_item_t         out_data
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("core took a second item right after the first");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_sync_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.step_count == 32'd0 |-> !out_data.sync_seen && !out_data.in_sync)
    else $error("sync reported with no step taken");

  a_sync_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.sync_seen |->
      out_data.sync_step != 32'd0 && out_data.sync_step <= out_data.step_count)
    else $error("first sync step out of range");

  a_in_sync_latched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.in_sync |-> out_data.sync_seen)
    else $error("in sync without sync latch");

endmodule

bind chaotic_drive_response_rk4_core cdrrk4_checker u_cdrrk4_checker (.*);

>>> tb/tb_top.sv
// Testbench for the drive-response RK4 core: random traffic checked against a fixed-point predictor.
`timescale 1ns / 1ps

module tb_top;
  import cdrrk4_pkg::*;

  localparam longint ONE_Q   = 64'sd1 << 24;
  localparam longint CYC_MAX = 64'd4000000;

  // Scoreboard: tracks the expected state of both oscillators and queues results.
  class rk4_scoreboard;
    int        gamma_q, alpha_q;
    longint    dt_q, tol_q;
    int        resp[3], drv[3];
    bit [31:0] steps, first_step;
    bit        latched;
    out_item_t pending[$];
    int        errors;

    function new();
      gamma_q = GAMMA_RST; alpha_q = ALPHA_RST; dt_q = STEP_RST; tol_q = TOL_RST;
      foreach (resp[j]) begin
        resp[j] = 0; drv[j] = 0;
      end
      steps = 0; first_step = 0; latched = 0; errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, bit [31:0] val);
      case (idx)
        REG_GAMMA: gamma_q = val;
        REG_ALPHA: alpha_q = val;
        REG_STEP:  dt_q = val[24:0];
        REG_TOL:   tol_q = val[15:0];
      endcase
    endfunction

    function int clip(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    // rounded product, shift s with round half up, floor
    function int qmul(longint a, longint b, int s);
      longint p;
      p = a * b + (64'sd1 <<< (s - 1));
      return clip(p >>> s);
    endfunction

    function void slope(input int v[3], output int d[3]);
      int xx, u, c, e;
      xx = qmul(v[0], v[0], 24);
      u = clip(longint'(clip(longint'(v[2]) - ONE_Q)) + xx);
      d[0] = clip(longint'(qmul(v[1], u, 24)) + qmul(gamma_q, v[0], 24));
      c = clip(longint'(clip(longint'(clip(3 * longint'(v[2]))) + ONE_Q)) - xx);
      d[1] = clip(longint'(qmul(v[0], c, 24)) + qmul(gamma_q, v[1], 24));
      e = clip(longint'(alpha_q) + qmul(v[0], v[1], 24));
      d[2] = clip(-2 * longint'(qmul(v[2], e, 24)));
    endfunction

    function void rk4_step(ref int v[3]);
      int k1[3], k2[3], k3[3], k4[3], t[3];
      longint acc, p, q;
      slope(v, k1);
      foreach (t[j]) t[j] = clip(longint'(v[j]) + qmul(dt_q, k1[j], 25));
      slope(t, k2);
      foreach (t[j]) t[j] = clip(longint'(v[j]) + qmul(dt_q, k2[j], 25));
      slope(t, k3);
      foreach (t[j]) t[j] = clip(longint'(v[j]) + qmul(dt_q, k3[j], 24));
      slope(t, k4);
      foreach (v[j]) begin
        acc = longint'(k1[j]) + 2 * longint'(k2[j]) + 2 * longint'(k3[j]) + k4[j];
        p = dt_q * acc + 3 * ONE_Q;
        q = p / (6 * ONE_Q);
        if ((p % (6 * ONE_Q)) != 0 && p < 0) q = q - 1;
        v[j] = clip(longint'(v[j]) + q);
      end
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      bit agree;
      longint df;
      agree = 0;
      if (it.action == 1'b0) begin
        resp[0] = it.load_resp_x;  resp[1] = it.load_resp_y;  resp[2] = it.load_resp_z;
        drv[0]  = it.load_drive_x; drv[1]  = it.load_drive_y; drv[2]  = it.load_drive_z;
        steps = 0; latched = 0; first_step = 0;
      end else begin
        resp[1] = drv[1];
        rk4_step(resp);
        rk4_step(drv);
        if (steps != 32'hffffffff) steps = steps + 1;
        agree = 1;
        foreach (drv[j]) begin
          df = longint'(drv[j]) - longint'(resp[j]);
          if (df < 0) df = -df;
          if (df > tol_q) agree = 0;
        end
        if (agree && !latched) begin
          latched = 1; first_step = steps;
        end
      end
      r.resp_x = resp[0]; r.resp_y = resp[1]; r.resp_z = resp[2];
      r.drive_x = drv[0]; r.drive_y = drv[1]; r.drive_z = drv[2];
      r.in_sync = agree; r.sync_seen = latched;
      r.sync_step = first_step; r.step_count = steps;
      pending.push_back(r);
    endfunction

    function void cmp(string nm, longint e, longint a);
      if (e != a) begin
        $display("%0t: mismatch %s expected %0d actual %0d", $time, nm, e, a);
        errors++;
      end
    endfunction

    function void check_result(out_item_t a);
      out_item_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("resp_x", e.resp_x, a.resp_x);
      cmp("resp_y", e.resp_y, a.resp_y);
      cmp("resp_z", e.resp_z, a.resp_z);
      cmp("drive_x", e.drive_x, a.drive_x);
      cmp("drive_y", e.drive_y, a.drive_y);
      cmp("drive_z", e.drive_z, a.drive_z);
      cmp("in_sync", e.in_sync, a.in_sync);
      cmp("sync_seen", e.sync_seen, a.sync_seen);
      cmp("sync_step", e.sync_step, a.sync_step);
      cmp("step_count", e.step_count, a.step_count);
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  rk4_scoreboard osc_sb;
  int            send_idle_pct;  // chance in percent of a sender gap cycle
  int            recv_idle_pct;  // chance in percent of a receiver stall cycle
  longint        cycles;

  chaotic_drive_response_rk4_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: the slowest correct run is far below this limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_MAX) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver side: random stalls, results checked at the accepting edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) osc_sb.check_result(out_data);
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Register write: setup phase, access phase, then the bus returns to idle.
  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    osc_sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Wait until every expected result has come back, then let the core settle.
  task automatic drain();
    while (osc_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic program_regs(logic [31:0] g, logic [31:0] a, logic [31:0] h,
                              logic [31:0] tol);
    drain();
    reg_write(REG_GAMMA, g);
    reg_write(REG_ALPHA, a);
    reg_write(REG_STEP, h);
    reg_write(REG_TOL, tol);
  endtask

  // Present one item and hold it until taken; gaps only after acceptance, so
  // in_valid never gets two assignments in one step.
  task automatic push_item(in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    osc_sb.note_input(it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= '{default: '0, action: $urandom_range(1)};
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  function automatic in_item_t load_item(int rx, int ry, int rz, int dx, int dy, int dz);
    in_item_t it;
    it.action = 1'b0;
    it.load_resp_x = rx;  it.load_resp_y = ry;  it.load_resp_z = rz;
    it.load_drive_x = dx; it.load_drive_y = dy; it.load_drive_z = dz;
    return it;
  endfunction

  function automatic in_item_t step_item();
    in_item_t it;
    it = '{default: '0};
    foreach (it.load_resp_x[b]) begin
      it.load_resp_x[b] = $urandom_range(1);
      it.load_drive_z[b] = $urandom_range(1);
    end
    it.action = 1'b1;
    return it;
  endfunction

  // Mostly values around the attractor, sometimes full range or a rail.
  function automatic int pick_q();
    int sel;
    sel = $urandom_range(99);
    if (sel < 75) return $signed($urandom_range(32'h0c00_0000)) - 32'sh0600_0000;
    if (sel < 90) return $urandom;
    if (sel < 95) return 32'sh7fffffff;
    return 32'sh80000000;
  endfunction

  // Load followed by a run of steps; the response often starts near the drive.
  task automatic run_sequences(int n_items);
    int sent, nstep, mode, dx, dy, dz;
    in_item_t it;
    sent = 0;
    while (sent < n_items) begin
      dx = pick_q(); dy = pick_q(); dz = pick_q();
      mode = $urandom_range(9);
      if (mode < 3)
        it = load_item(dx, dy, dz, dx, dy, dz);
      else if (mode < 6)
        it = load_item(dx + $signed($urandom_range(64)) - 32, pick_q(),
                       dz + $signed($urandom_range(64)) - 32, dx, dy, dz);
      else
        it = load_item(pick_q(), pick_q(), pick_q(), dx, dy, dz);
      push_item(it);
      sent++;
      nstep = $urandom_range(12, 1);
      repeat (nstep) begin
        if ($urandom_range(19) == 0)
          it = load_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
          it = step_item();
        push_item(it);
        sent++;
      end
    end
  endtask

  initial begin
    osc_sb = new();
    cycles = 0;
    send_idle_pct = 33;
    recv_idle_pct = 59;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset coefficients, zero state, rails, alternating bits, sync.
    push_item(step_item());
    push_item(load_item(0, 0, 0, 0, 0, 0));
    push_item(step_item());
    push_item(load_item(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                        32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    push_item(step_item());
    push_item(load_item(32'sh80000000, 32'sh80000000, 32'sh80000000,
                        32'sh80000000, 32'sh80000000, 32'sh80000000));
    push_item(step_item());
    push_item(load_item(32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa,
                        32'sh55555555, 32'shaaaaaaaa, 32'sh55555555));
    push_item(step_item());
    // identical states agree on the first step
    push_item(load_item(32'sh0100_0000, 32'sh0080_0000, 32'sh0040_0000,
                        32'sh0100_0000, 32'sh0080_0000, 32'sh0040_0000));
    repeat (3) push_item(step_item());
    // a few LSBs apart: within tolerance
    push_item(load_item(32'sh0100_0004, 32'sh0, 32'sh0040_0000,
                        32'sh0100_0000, 32'sh0080_0000, 32'sh0040_0003));
    repeat (2) push_item(step_item());
    // far apart: does not agree
    push_item(load_item(32'shfe00_0000, 32'sh0100_0000, 32'sh0200_0000,
                        32'sh0100_0000, 32'sh0080_0000, 32'sh0040_0000));
    repeat (3) push_item(step_item());

    // Hold off the sender until the core has nothing left in flight.
    in_valid <= 1'b0;
    drain();

    // Phase 1: sender idles 33%, receiver 59%.
    send_idle_pct = 33; recv_idle_pct = 59;
    program_regs(32'h00f0_0000, 32'h0140_0000, 32'd167772, 32'd16);
    run_sequences(500);
    in_valid <= 1'b0;

    // Coefficient and step rails, widest tolerance.
    program_regs(32'h8000_0000, 32'h7fff_ffff, 32'h0100_0000, 32'hffff_ffff);
    run_sequences(60);
    in_valid <= 1'b0;
    program_regs(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    run_sequences(60);
    in_valid <= 1'b0;

    // Phase 2: roles swapped.
    send_idle_pct = 59; recv_idle_pct = 33;
    program_regs(32'd14596177, 32'd18454938, 32'hfe00_0000 | 32'd167772, 32'd8);
    run_sequences(480);
    in_valid <= 1'b0;

    // Phase 3: no idling, coarser step.
    send_idle_pct = 0; recv_idle_pct = 0;
    program_regs(32'hff00_0000, 32'h00c0_0000, 32'h0010_0000, 32'h0001_0100);
    run_sequences(480);
    in_valid <= 1'b0;

    while (osc_sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (osc_sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> chaotic_drive_response_rk4_core.f
hdl/cdrrk4_pkg.sv
hdl/cdrrk4_mul.sv
hdl/cdrrk4_div6.sv
hdl/chaotic_drive_response_rk4_core.sv
hdl/cdrrk4_checker.sv
tb/tb_top.sv
